/* design/mi3_pkg.sv */
`default_nettype none
package mi3_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// Entry indices (row * 3 + column) of a*b - c*d for each adjugate cell.
	localparam int unsigned COF_IDX [9][4] = '{
		'{4, 8, 5, 7},
		'{2, 7, 1, 8},
		'{1, 5, 2, 4},
		'{5, 6, 3, 8},
		'{0, 8, 2, 6},
		'{2, 3, 0, 5},
		'{3, 7, 4, 6},
		'{1, 6, 0, 7},
		'{0, 4, 1, 3}
	};

endpackage
`default_nettype wire

/* design/mi3_in_if.sv */
`default_nettype none
interface mi3_in_if
	import mi3_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;

	modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
		input ready);
	modport sink (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
		output ready);
endinterface
`default_nettype wire

/* design/mi3_out_if.sv */
`default_nettype none
interface mi3_out_if
	import mi3_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
	logic                         singular;

	modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
		singular, input ready);
	modport sink (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
		singular, output ready);
endinterface
`default_nettype wire

/* design/mi3_div.sv */
`default_nettype none
module mi3_div
	import mi3_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       en,
	input  wire logic                                       in_valid,
	input  wire logic                                       in_sing,
	input  wire logic                                       in_neg,
	input  wire logic [2*DATA_WIDTH+2*FRAC_BITS:0]          num,
	input  wire logic [3*DATA_WIDTH+2:0]                    den,
	output logic                                            out_valid,
	output logic                                            out_sing,
	output logic signed [DATA_WIDTH-1:0]                    res
);
	localparam int unsigned K   = DATA_WIDTH + 1;
	localparam int unsigned DW  = 3 * DATA_WIDTH + 3;
	localparam int unsigned NMW = 2 * DATA_WIDTH + 2 * FRAC_BITS + 1;
	localparam int unsigned XW  = NMW + DW + K;

	logic          valid_s [K+1];
	logic          sing_s  [K+1];
	logic          neg_s   [K+1];
	logic          big_s   [K+1];
	logic [DW-1:0] den_s   [K+1];
	logic [DW-1:0] rem_s   [K+1];
	logic [K-1:0]  nlo_s   [K+1];
	logic [K-1:0]  q_s     [K+1];

	logic [XW-1:0] num_x;
	logic [XW-1:0] den_x;

	assign num_x = XW'(num);
	assign den_x = XW'(den) << K;

	// A quotient of 2^K or more saturates anyway, so only K bits are developed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sing_s[0] <= in_sing;
			neg_s[0]  <= in_neg;
			big_s[0]  <= num_x >= den_x;
			den_s[0]  <= den;
			rem_s[0]  <= DW'(num_x >> K);
			nlo_s[0]  <= num[K-1:0];
			q_s[0]    <= '0;
		end
	end

	for (genvar j = 0; j < K; j++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		logic        ge;

		assign trial = {rem_s[j], nlo_s[j][K-1]};
		assign diff  = trial - {1'b0, den_s[j]};
		assign ge    = trial >= {1'b0, den_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j+1] <= 1'b0;
			end else if (en) begin
				valid_s[j+1] <= valid_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sing_s[j+1] <= sing_s[j];
				neg_s[j+1]  <= neg_s[j];
				big_s[j+1]  <= big_s[j];
				den_s[j+1]  <= den_s[j];
				rem_s[j+1]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
				nlo_s[j+1]  <= {nlo_s[j][K-2:0], 1'b0};
				q_s[j+1]    <= {q_s[j][K-2:0], ge};
			end
		end
	end

	logic [DW:0]  twice;
	logic [K:0]   q_rnd;
	logic [K:0]   lim;
	logic [K:0]   q_sat;
	logic [DATA_WIDTH-1:0] mag;
	logic [DATA_WIDTH-1:0] res_d;

	always_comb begin
		twice = {rem_s[K], 1'b0};
		q_rnd = {1'b0, q_s[K]} + (K+1)'(twice >= {1'b0, den_s[K]});
		lim   = ((K+1)'(1) << (DATA_WIDTH - 1)) - (K+1)'(!neg_s[K]);
		q_sat = (big_s[K] || q_rnd > lim) ? lim : q_rnd;
		mag   = q_sat[DATA_WIDTH-1:0];
		if (sing_s[K]) begin
			res_d = '0;
		end else if (neg_s[K]) begin
			res_d = -mag;
		end else begin
			res_d = mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s[K];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_sing <= sing_s[K];
			res      <= res_d;
		end
	end
endmodule
`default_nettype wire

/* design/matrix3_inverse_unit.sv */
`default_nettype none
// Inverts one 3x3 signed fixed-point matrix per request and can take a new
// request on every clock cycle while the output is not stalled. The adjugate
// and determinant are formed exactly, and each inverse entry is the rounded
// (nearest, ties away from zero) and saturated quotient of a cofactor by the
// determinant; a zero determinant gives the zero matrix with singular set. The
// pipeline has six stages of products and sums, then a restoring divider per
// entry that resolves one quotient bit per stage, then rounding. A stalled
// output holds the whole pipeline, so ready follows the output side.
module matrix3_inverse_unit
	import mi3_pkg::*;
#(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mi3_in_if.sink     in_ch,
	mi3_out_if.source  out_ch
);
	localparam int unsigned D   = DATA_WIDTH;
	localparam int unsigned CW  = 2 * D + 1;
	localparam int unsigned DW  = 3 * D + 3;
	localparam int unsigned NMW = 2 * D + 2 * FRAC_BITS + 1;

	logic en;
	logic out_valid;

	assign en          = !out_valid || out_ch.ready;
	assign in_ch.ready = en;

	logic signed [D-1:0] m_in [9];

	assign m_in[0] = in_ch.m11;
	assign m_in[1] = in_ch.m12;
	assign m_in[2] = in_ch.m13;
	assign m_in[3] = in_ch.m21;
	assign m_in[4] = in_ch.m22;
	assign m_in[5] = in_ch.m23;
	assign m_in[6] = in_ch.m31;
	assign m_in[7] = in_ch.m32;
	assign m_in[8] = in_ch.m33;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid && in_ch.ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	logic signed [2*D-1:0]  p_s1   [18];
	logic signed [D-1:0]    mr_s1  [3];
	logic signed [D-1:0]    mr_s2  [3];
	logic signed [CW-1:0]   cof_s2 [9];
	logic signed [CW-1:0]   cof_s3 [9];
	logic signed [CW-1:0]   cof_s4 [9];
	logic signed [CW-1:0]   cof_s5 [9];
	logic signed [2*D+1:0]  ml_s3  [3];
	logic signed [2*D-1:0]  mh_s3  [3];
	logic signed [DW-1:0]   term_s4 [3];
	logic signed [DW-1:0]   det_s5;
	logic [DW-1:0]          den_s6;
	logic                   sing_s6;
	logic [NMW-1:0]         num_s6 [9];
	logic                   neg_s6 [9];

	for (genvar k = 0; k < 9; k++) begin : g_cof
		always_ff @(posedge clk) begin
			if (en) begin
				p_s1[2*k]   <= m_in[COF_IDX[k][0]] * m_in[COF_IDX[k][1]];
				p_s1[2*k+1] <= m_in[COF_IDX[k][2]] * m_in[COF_IDX[k][3]];
				cof_s2[k]   <= CW'(p_s1[2*k]) - CW'(p_s1[2*k+1]);
				cof_s3[k]   <= cof_s2[k];
				cof_s4[k]   <= cof_s3[k];
				cof_s5[k]   <= cof_s4[k];
			end
		end
	end

	// Row one times the first adjugate column; each cofactor is split into a
	// signed upper part and an unsigned lower part to keep the multipliers narrow.
	for (genvar i = 0; i < 3; i++) begin : g_det
		logic signed [D+1:0] lo;
		logic signed [D-1:0] hi;

		assign lo = signed'({1'b0, cof_s2[3*i][D:0]});
		assign hi = cof_s2[3*i][CW-1:D+1];

		always_ff @(posedge clk) begin
			if (en) begin
				mr_s1[i]   <= m_in[i];
				mr_s2[i]   <= mr_s1[i];
				ml_s3[i]   <= mr_s2[i] * lo;
				mh_s3[i]   <= mr_s2[i] * hi;
				term_s4[i] <= (DW'(mh_s3[i]) <<< (D + 1)) + DW'(ml_s3[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s5  <= term_s4[0] + term_s4[1] + term_s4[2];
			den_s6  <= det_s5[DW-1] ? DW'(-det_s5) : DW'(det_s5);
			sing_s6 <= det_s5 == '0;
		end
	end

	for (genvar k = 0; k < 9; k++) begin : g_num
		logic [CW-1:0] cmag;

		assign cmag = cof_s5[k][CW-1] ? CW'(-cof_s5[k]) : CW'(cof_s5[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				num_s6[k] <= NMW'(cmag) << (2 * FRAC_BITS);
				neg_s6[k] <= cof_s5[k][CW-1] ^ det_s5[DW-1];
			end
		end
	end

	logic                  lane_valid [9];
	logic                  lane_sing  [9];
	logic signed [D-1:0]   res        [9];

	for (genvar k = 0; k < 9; k++) begin : g_lane
		mi3_div #(
			.DATA_WIDTH (DATA_WIDTH),
			.FRAC_BITS  (FRAC_BITS)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (v_s6),
			.in_sing   (sing_s6),
			.in_neg    (neg_s6[k]),
			.num       (num_s6[k]),
			.den       (den_s6),
			.out_valid (lane_valid[k]),
			.out_sing  (lane_sing[k]),
			.res       (res[k])
		);
	end

	// All lanes move in lockstep, so the first one stands for the rest.
	assign out_valid       = lane_valid[0];
	assign out_ch.valid    = out_valid;
	assign out_ch.singular = lane_sing[0];
	assign out_ch.r11      = res[0];
	assign out_ch.r12      = res[1];
	assign out_ch.r13      = res[2];
	assign out_ch.r21      = res[3];
	assign out_ch.r22      = res[4];
	assign out_ch.r23      = res[5];
	assign out_ch.r31      = res[6];
	assign out_ch.r32      = res[7];
	assign out_ch.r33      = res[8];
endmodule
`default_nettype wire
